/* design/assert_macros.svh */
// Assertion helpers shared by the RTL. Both macros sample on the rising edge
// of clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* design/hgf_pkg.sv */
`timescale 1ns / 1ps

package hgf_pkg;

  localparam int COORD_W    = 8;
  localparam int SIZE_W     = 9;
  localparam int IDX_W      = 24;
  localparam int FACE_W     = 26;
  localparam int GROUP_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Smallest legal grid dimension in points.
  localparam logic [SIZE_W-1:0] MIN_POINTS = 9'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_N_STREAM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_N_PITCH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_N_SPAN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLADE_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLADE_END   = 3'd4;

  // Boundary group codes.
  localparam logic [GROUP_W-1:0] BG_INTERIOR  = 3'd0;
  localparam logic [GROUP_W-1:0] BG_HUB       = 3'd1;
  localparam logic [GROUP_W-1:0] BG_SHROUD    = 3'd2;
  localparam logic [GROUP_W-1:0] BG_INFLOW    = 3'd3;
  localparam logic [GROUP_W-1:0] BG_OUTFLOW   = 3'd4;
  localparam logic [GROUP_W-1:0] BG_PERIODIC1 = 3'd5;
  localparam logic [GROUP_W-1:0] BG_PERIODIC2 = 3'd6;
  localparam logic [GROUP_W-1:0] BG_BLADE     = 3'd7;

  // Clamped grid description handed from the register block to the sequencer.
  typedef struct packed {
    logic [SIZE_W-1:0]  ns;
    logic [SIZE_W-1:0]  np;
    logic [SIZE_W-1:0]  nk;
    logic [SIZE_W-1:0]  cs;
    logic [SIZE_W-1:0]  cp;
    logic [COORD_W-1:0] blade_start;
    logic [COORD_W-1:0] blade_end;
  } grid_t;

  // One request to the shared multiply-add unit: a * b + c, modulo 2^24.
  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } mac_req_t;

endpackage

/* design/hgf_stream_if.sv */
`timescale 1ns / 1ps

interface hgf_in_if;
  logic                        valid;
  logic                        ready;
  logic [hgf_pkg::COORD_W-1:0] cell_i;
  logic [hgf_pkg::COORD_W-1:0] cell_j;
  logic [hgf_pkg::COORD_W-1:0] cell_k;
  logic                        restart_count;

  modport source (output valid, output cell_i, output cell_j, output cell_k,
                  output restart_count, input ready);
  modport sink (input valid, input cell_i, input cell_j, input cell_k,
                input restart_count, output ready);
endinterface

interface hgf_out_if;
  logic                        valid;
  logic                        ready;
  logic [hgf_pkg::FACE_W-1:0]  face_number;
  logic [hgf_pkg::IDX_W-1:0]   vertex_a;
  logic [hgf_pkg::IDX_W-1:0]   vertex_b;
  logic [hgf_pkg::IDX_W-1:0]   vertex_c;
  logic [hgf_pkg::IDX_W-1:0]   vertex_d;
  logic [hgf_pkg::IDX_W-1:0]   owner_cell;
  logic [hgf_pkg::IDX_W-1:0]   neighbour_cell;
  logic                        has_neighbour;
  logic [hgf_pkg::GROUP_W-1:0] boundary_group;
  logic                        last_face;

  modport source (output valid, output face_number, output vertex_a, output vertex_b,
                  output vertex_c, output vertex_d, output owner_cell,
                  output neighbour_cell, output has_neighbour, output boundary_group,
                  output last_face, input ready);
  modport sink (input valid, input face_number, input vertex_a, input vertex_b,
                input vertex_c, input vertex_d, input owner_cell, input neighbour_cell,
                input has_neighbour, input boundary_group, input last_face,
                output ready);
endinterface

/* design/hex_grid_face_enumerator.sv */
`timescale 1ns / 1ps
// Face enumerator for a structured hexahedral grid.
//
// The in_ch channel takes one word per cell: its (i, j, k) coordinates and a
// restart flag that resets face numbering to zero before this cell's faces.
// The out_ch channel returns three to six words per cell, one per face, in the
// order hub, k+1, j=0, j+1, i=0, i+1; last_face marks the cell's final face.
// Grid sizes and the blade range are written through the cfg_ port while the
// block is idle; a write to an index beyond the register list is ignored.
//
// Timing: after a cell is accepted, sixteen multiply-add passes through the
// single shared unit (plus a write-back of the last result) form the vertex
// and cell indices, and the first face is then loaded into the output
// register. Faces then leave one per cycle while the receiver keeps up, and
// the next cell can be taken in the cycle after the last face is loaded. The
// shared unit sets the rate at which cells pass.
//
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// face counter and empties the output register. When the receiver stalls,
// the pending face holds in the output register and emission pauses.

`include "assert_macros.svh"

module hex_grid_face_enumerator #(
  parameter int MAX_POINTS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [hgf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hgf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  hgf_in_if.sink                         in_ch,
  hgf_out_if.source                      out_ch
);

  localparam int SW = hgf_pkg::SIZE_W;
  localparam int CW = hgf_pkg::COORD_W;

  // Largest grid dimension the size registers can reach after clamping.
  localparam int SIZE_CAP = (1 << SW) - 1;
  localparam logic [SW-1:0] MAX_SZ =
    (MAX_POINTS > SIZE_CAP) ? SW'(SIZE_CAP) : SW'(MAX_POINTS);

  logic [SW-1:0] n_stream_r, n_pitch_r, n_span_r;
  logic [CW-1:0] blade_start_r, blade_end_r;

  // Register writes; software must write only while idle; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_stream_r    <= hgf_pkg::MIN_POINTS;
      n_pitch_r     <= hgf_pkg::MIN_POINTS;
      n_span_r      <= hgf_pkg::MIN_POINTS;
      blade_start_r <= '0;
      blade_end_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hgf_pkg::CFG_N_STREAM:    n_stream_r    <= cfg_wr_data;
        hgf_pkg::CFG_N_PITCH:     n_pitch_r     <= cfg_wr_data;
        hgf_pkg::CFG_N_SPAN:      n_span_r      <= cfg_wr_data;
        hgf_pkg::CFG_BLADE_START: blade_start_r <= cfg_wr_data[CW-1:0];
        hgf_pkg::CFG_BLADE_END:   blade_end_r   <= cfg_wr_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // A size below two acts as two, one above the cap acts as the cap.
  function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] n);
    logic [SW-1:0] r;
    if (n < hgf_pkg::MIN_POINTS) begin
      r = hgf_pkg::MIN_POINTS;
    end else if (n > MAX_SZ) begin
      r = MAX_SZ;
    end else begin
      r = n;
    end
    return r;
  endfunction

  hgf_pkg::grid_t grid;

  always_comb begin
    grid.ns          = clamp_size(n_stream_r);
    grid.np          = clamp_size(n_pitch_r);
    grid.nk          = clamp_size(n_span_r);
    grid.cs          = grid.ns - SW'(1);
    grid.cp          = grid.np - SW'(1);
    grid.blade_start = blade_start_r;
    grid.blade_end   = blade_end_r;
  end

  hgf_pkg::mac_req_t         mac_req;
  logic [hgf_pkg::IDX_W-1:0] mac_res;

  hgf_mac u_mac (
    .clk   (clk),
    .req   (mac_req),
    .res_r (mac_res)
  );

  hgf_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .grid    (grid),
    .mac_req (mac_req),
    .mac_res (mac_res),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // Terms used by the checks below.
  logic in_take, nb_flag_ok, stray_nb;

  assign in_take    = in_ch.valid && in_ch.ready;
  assign nb_flag_ok = (out_ch.has_neighbour == (out_ch.boundary_group == hgf_pkg::BG_INTERIOR));
  assign stray_nb   = !out_ch.has_neighbour && (out_ch.neighbour_cell != '0);

  // Once a cell is taken, the sequencer is busy for at least the next cycle.
  `ASSERT_CLK(a_busy_after_accept, in_take |=> !in_ch.ready, "ready after accept")
  // Only interior faces carry a neighbour, and every interior face has one.
  `ASSERT_CLK(a_group_matches_nb, out_ch.valid |-> nb_flag_ok, "group and flag disagree")
  // A boundary face reports a zero neighbour index.
  `ASSERT_NEVER(a_boundary_nb_zero, out_ch.valid && stray_nb, "boundary face with a neighbour")

endmodule

/* design/hgf_mac.sv */
`timescale 1ns / 1ps

// Shared multiply-add unit with a registered result, one request per cycle.
module hgf_mac (
  input  logic                      clk,
  input  hgf_pkg::mac_req_t         req,
  output logic [hgf_pkg::IDX_W-1:0] res_r
);

  localparam int W = hgf_pkg::IDX_W;

  // Only the low W bits of the product are ever needed.
  logic [W-1:0] prod;

  assign prod = req.a * req.b;

  always_ff @(posedge clk) begin
    res_r <= prod + req.c;
  end

endmodule

/* design/hgf_seq.sv */
`timescale 1ns / 1ps

// Per-cell sequencer: runs the index arithmetic through the shared unit, then
// hands the cell's faces one at a time to the output register.
module hgf_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hgf_pkg::grid_t            grid,
  output hgf_pkg::mac_req_t         mac_req,
  input  logic [hgf_pkg::IDX_W-1:0] mac_res,
  hgf_in_if.sink                    in_ch,
  hgf_out_if.source                 out_ch
);

  localparam int W  = hgf_pkg::IDX_W;
  localparam int CW = hgf_pkg::COORD_W;
  localparam int SW = hgf_pkg::SIZE_W;
  localparam int FW = hgf_pkg::FACE_W;

  // Operation codes of the arithmetic schedule. An operation only reads
  // results of operations issued at least two slots earlier.
  localparam logic [3:0] OP_S    = 4'd0;
  localparam logic [3:0] OP_CP   = 4'd1;
  localparam logic [3:0] OP_V0P  = 4'd2;
  localparam logic [3:0] OP_OP   = 4'd3;
  localparam logic [3:0] OP_V0   = 4'd4;
  localparam logic [3:0] OP_O    = 4'd5;
  localparam logic [3:0] OP_V100 = 4'd6;
  localparam logic [3:0] OP_V010 = 4'd7;
  localparam logic [3:0] OP_V001 = 4'd8;
  localparam logic [3:0] OP_NI   = 4'd9;
  localparam logic [3:0] OP_V110 = 4'd10;
  localparam logic [3:0] OP_V011 = 4'd11;
  localparam logic [3:0] OP_V101 = 4'd12;
  localparam logic [3:0] OP_NJ   = 4'd13;
  localparam logic [3:0] OP_V111 = 4'd14;
  localparam logic [3:0] OP_NK   = 4'd15;
  localparam logic [4:0] STEP_DONE = 5'd16;

  // Face kinds, as bit positions of the pending mask, in emission order.
  localparam int FK_HUB = 0;
  localparam int FK_KP  = 1;
  localparam int FK_J0  = 2;
  localparam int FK_JP  = 3;
  localparam int FK_I0  = 4;
  localparam int FK_IP  = 5;

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;

  state_t state_r;
  logic [4:0] step_r;
  logic [3:0] wb_op_r;
  logic       wb_vld_r;
  logic [5:0] pend_r;
  logic [hgf_pkg::FACE_W-1:0] cnt_r;

  logic [CW-1:0] i_r, j_r, k_r;
  logic last_i_r, last_j_r, last_k_r, blade_r;

  logic [W-1:0] s_r, cpp_r, v0p_r, op_r, own_r;
  logic [W-1:0] c000_r, c100_r, c010_r, c110_r, c001_r, c101_r, c011_r, c111_r;
  logic [W-1:0] ni_r, nj_r, nk_r;

  // Output register.
  logic                        out_valid_r;
  logic [hgf_pkg::FACE_W-1:0]  face_number_r;
  logic [W-1:0]                vertex_a_r, vertex_b_r, vertex_c_r, vertex_d_r;
  logic [W-1:0]                owner_cell_r, neighbour_cell_r;
  logic                        has_neighbour_r;
  logic [hgf_pkg::GROUP_W-1:0] boundary_group_r;
  logic                        last_face_r;

  // Coordinate saturation at accept time.
  logic [SW-1:0] lim_i, lim_j, lim_k;
  logic [CW-1:0] ci, cj, ck;

  assign lim_i = grid.ns - hgf_pkg::MIN_POINTS;
  assign lim_j = grid.np - hgf_pkg::MIN_POINTS;
  assign lim_k = grid.nk - hgf_pkg::MIN_POINTS;
  assign ci = ({1'b0, in_ch.cell_i} > lim_i) ? lim_i[CW-1:0] : in_ch.cell_i;
  assign cj = ({1'b0, in_ch.cell_j} > lim_j) ? lim_j[CW-1:0] : in_ch.cell_j;
  assign ck = ({1'b0, in_ch.cell_k} > lim_k) ? lim_k[CW-1:0] : in_ch.cell_k;

  logic in_fire, out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Operand selection for the shared unit.
  logic [W-1:0] one, z_ns, z_np, z_cs, z_cp, z_i, z_j, z_k;

  assign one  = W'(1);
  assign z_ns = W'(grid.ns);
  assign z_np = W'(grid.np);
  assign z_cs = W'(grid.cs);
  assign z_cp = W'(grid.cp);
  assign z_i  = W'(i_r);
  assign z_j  = W'(j_r);
  assign z_k  = W'(k_r);

  always_comb begin
    unique case (step_r[3:0])
      OP_S:    mac_req = '{a: z_ns,   b: z_np,  c: '0};
      OP_CP:   mac_req = '{a: z_cs,   b: z_cp,  c: '0};
      OP_V0P:  mac_req = '{a: z_j,    b: z_ns,  c: z_i};
      OP_OP:   mac_req = '{a: z_j,    b: z_cs,  c: z_i};
      OP_V0:   mac_req = '{a: z_k,    b: s_r,   c: v0p_r};
      OP_O:    mac_req = '{a: z_k,    b: cpp_r, c: op_r};
      OP_V100: mac_req = '{a: c000_r, b: one,   c: one};
      OP_V010: mac_req = '{a: c000_r, b: one,   c: z_ns};
      OP_V001: mac_req = '{a: c000_r, b: one,   c: s_r};
      OP_NI:   mac_req = '{a: own_r,  b: one,   c: one};
      OP_V110: mac_req = '{a: c010_r, b: one,   c: one};
      OP_V011: mac_req = '{a: c001_r, b: one,   c: z_ns};
      OP_V101: mac_req = '{a: c001_r, b: one,   c: one};
      OP_NJ:   mac_req = '{a: own_r,  b: one,   c: z_cs};
      OP_V111: mac_req = '{a: c011_r, b: one,   c: one};
      OP_NK:   mac_req = '{a: own_r,  b: one,   c: cpp_r};
      default: mac_req = '{a: '0,     b: '0,    c: '0};
    endcase
  end

  // Pick the earliest pending face and build its fields.
  logic [5:0]                  f_bit;
  logic [W-1:0]                f_a, f_b, f_c, f_d, f_nb;
  logic                        f_has_nb;
  logic [hgf_pkg::GROUP_W-1:0] f_grp;
  logic [5:0]                  pend_left;

  always_comb begin
    f_bit    = '0;
    f_a      = c100_r;
    f_b      = c101_r;
    f_c      = c111_r;
    f_d      = c110_r;
    f_has_nb = !last_i_r;
    f_nb     = ni_r;
    f_grp    = last_i_r ? hgf_pkg::BG_OUTFLOW : hgf_pkg::BG_INTERIOR;
    priority if (pend_r[FK_HUB]) begin
      f_bit[FK_HUB] = 1'b1;
      f_a = c000_r; f_b = c100_r; f_c = c110_r; f_d = c010_r;
      f_has_nb = 1'b0;
      f_grp = hgf_pkg::BG_HUB;
    end else if (pend_r[FK_KP]) begin
      f_bit[FK_KP] = 1'b1;
      f_a = c001_r; f_b = c011_r; f_c = c111_r; f_d = c101_r;
      f_has_nb = !last_k_r;
      f_nb = nk_r;
      f_grp = last_k_r ? hgf_pkg::BG_SHROUD : hgf_pkg::BG_INTERIOR;
    end else if (pend_r[FK_J0]) begin
      f_bit[FK_J0] = 1'b1;
      f_a = c000_r; f_b = c001_r; f_c = c101_r; f_d = c100_r;
      f_has_nb = 1'b0;
      f_grp = blade_r ? hgf_pkg::BG_BLADE : hgf_pkg::BG_PERIODIC1;
    end else if (pend_r[FK_JP]) begin
      f_bit[FK_JP] = 1'b1;
      f_a = c010_r; f_b = c110_r; f_c = c111_r; f_d = c011_r;
      f_has_nb = !last_j_r;
      f_nb = nj_r;
      if (!last_j_r) begin
        f_grp = hgf_pkg::BG_INTERIOR;
      end else begin
        f_grp = blade_r ? hgf_pkg::BG_BLADE : hgf_pkg::BG_PERIODIC2;
      end
    end else if (pend_r[FK_I0]) begin
      f_bit[FK_I0] = 1'b1;
      f_a = c000_r; f_b = c010_r; f_c = c011_r; f_d = c001_r;
      f_has_nb = 1'b0;
      f_grp = hgf_pkg::BG_INFLOW;
    end else begin
      f_bit[FK_IP] = 1'b1;
    end
  end

  assign pend_left = pend_r & ~f_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      wb_vld_r    <= 1'b0;
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // While emitting, the output register's valid is handled below.
      if (out_ch.ready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            i_r      <= ci;
            j_r      <= cj;
            k_r      <= ck;
            last_i_r <= ({1'b0, ci} == lim_i);
            last_j_r <= ({1'b0, cj} == lim_j);
            last_k_r <= ({1'b0, ck} == lim_k);
            blade_r  <= (ci >= grid.blade_start) && (ci < grid.blade_end);
            pend_r   <= {1'b1, ci == '0, 1'b1, cj == '0, 1'b1, ck == '0};
            if (in_ch.restart_count) begin
              cnt_r <= '0;
            end
            step_r   <= '0;
            wb_vld_r <= 1'b0;
            state_r  <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (wb_vld_r) begin
            unique case (wb_op_r)
              OP_S:    s_r    <= mac_res;
              OP_CP:   cpp_r  <= mac_res;
              OP_V0P:  v0p_r  <= mac_res;
              OP_OP:   op_r   <= mac_res;
              OP_V0:   c000_r <= mac_res;
              OP_O:    own_r  <= mac_res;
              OP_V100: c100_r <= mac_res;
              OP_V010: c010_r <= mac_res;
              OP_V001: c001_r <= mac_res;
              OP_NI:   ni_r   <= mac_res;
              OP_V110: c110_r <= mac_res;
              OP_V011: c011_r <= mac_res;
              OP_V101: c101_r <= mac_res;
              OP_NJ:   nj_r   <= mac_res;
              OP_V111: c111_r <= mac_res;
              OP_NK:   nk_r   <= mac_res;
              default: ;
            endcase
          end
          wb_op_r  <= step_r[3:0];
          wb_vld_r <= (step_r != STEP_DONE);
          if (step_r == STEP_DONE) begin
            state_r <= ST_EMIT;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            face_number_r    <= cnt_r;
            vertex_a_r       <= f_a;
            vertex_b_r       <= f_b;
            vertex_c_r       <= f_c;
            vertex_d_r       <= f_d;
            owner_cell_r     <= own_r;
            neighbour_cell_r <= f_has_nb ? f_nb : '0;
            has_neighbour_r  <= f_has_nb;
            boundary_group_r <= f_grp;
            last_face_r      <= (pend_left == '0);
            cnt_r            <= cnt_r + FW'(1);
            pend_r           <= pend_left;
            if (pend_left == '0) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.face_number    = face_number_r;
  assign out_ch.vertex_a       = vertex_a_r;
  assign out_ch.vertex_b       = vertex_b_r;
  assign out_ch.vertex_c       = vertex_c_r;
  assign out_ch.vertex_d       = vertex_d_r;
  assign out_ch.owner_cell     = owner_cell_r;
  assign out_ch.neighbour_cell = neighbour_cell_r;
  assign out_ch.has_neighbour  = has_neighbour_r;
  assign out_ch.boundary_group = boundary_group_r;
  assign out_ch.last_face      = last_face_r;

endmodule
